// File: hw/rtl/mi3_pkg.sv
package mi3_pkg;

    localparam int EW    = 16;
    localparam int PW    = 2 * EW;
    localparam int CW    = PW + 1;
    localparam int DPW   = EW + CW;
    localparam int DW    = DPW + 1;
    localparam int MW    = DW - 1;
    localparam int QW    = 32;
    localparam int NL    = 9;
    localparam int NCELL = QW;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [EW-1:0] ent_t;

    typedef struct packed {
        ent_t a00;
        ent_t a01;
        ent_t a02;
        ent_t a10;
        ent_t a11;
        ent_t a12;
        ent_t a20;
        ent_t a21;
        ent_t a22;
    } mat_t;

    typedef struct packed {
        logic                 singular;
        logic signed [QW-1:0] b00;
        logic signed [QW-1:0] b01;
        logic signed [QW-1:0] b02;
        logic signed [QW-1:0] b10;
        logic signed [QW-1:0] b11;
        logic signed [QW-1:0] b12;
        logic signed [QW-1:0] b20;
        logic signed [QW-1:0] b21;
        logic signed [QW-1:0] b22;
    } inv_t;

    typedef struct packed {
        logic [MW-1:0] rem;
        logic [QW-1:0] lo;
        logic [QW-1:0] q;
    } lane_t;

    typedef lane_t [NL-1:0] lanes_t;

    typedef struct packed {
        logic          vld;
        logic          sing;
        logic [MW-1:0] den;
        logic [NL-1:0] neg;
        logic [NL-1:0] ovf;
    } ctl_t;

endpackage

// File: hw/rtl/mi3_front.sv
module mi3_front #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld,
    input  mi3_pkg::mat_t   mat,
    output mi3_pkg::ctl_t   ctl,
    output mi3_pkg::lanes_t lanes
);
    import mi3_pkg::*;

    ent_t m [3][3];

    logic signed [PW-1:0]  p1_reg [3][3];
    logic signed [PW-1:0]  p2_reg [3][3];
    logic signed [CW-1:0]  cof2_reg [3][3];
    logic signed [CW-1:0]  cof3_reg [3][3];
    logic signed [CW-1:0]  cof4_reg [3][3];
    logic signed [DPW-1:0] dp_reg [3];
    logic signed [DW-1:0]  det_reg;
    ent_t                  r01_reg [3];
    ent_t                  r02_reg [3];
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  v4_reg;

    ctl_t   ctl_reg;
    ctl_t   ctl_next;
    lanes_t lanes_reg;
    lanes_t lanes_next;

    assign m[0][0] = mat.a00;
    assign m[0][1] = mat.a01;
    assign m[0][2] = mat.a02;
    assign m[1][0] = mat.a10;
    assign m[1][1] = mat.a11;
    assign m[1][2] = mat.a12;
    assign m[2][0] = mat.a20;
    assign m[2][1] = mat.a21;
    assign m[2][2] = mat.a22;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            localparam int R1 = (r + 1) % 3;
            localparam int R2 = (r + 2) % 3;
            localparam int C1 = (c + 1) % 3;
            localparam int C2 = (c + 2) % 3;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p1_reg[r][c]   <= PW'(m[R1][C1]) * PW'(m[R2][C2]);
                    p2_reg[r][c]   <= PW'(m[R1][C2]) * PW'(m[R2][C1]);
                    cof2_reg[r][c] <= CW'(p1_reg[r][c]) - CW'(p2_reg[r][c]);
                    cof3_reg[r][c] <= cof2_reg[r][c];
                    cof4_reg[r][c] <= cof3_reg[r][c];
                end
            end
        end
    end

    for (genvar j = 0; j < 3; j++)
    begin : g_dp
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r01_reg[j] <= m[0][j];
                r02_reg[j] <= r01_reg[j];
                dp_reg[j]  <= DPW'(r02_reg[j]) * DPW'(cof2_reg[0][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= DW'(dp_reg[0]) + DW'(dp_reg[1]) + DW'(dp_reg[2]);
        end
    end

    always_comb
    begin
        logic signed [CW-1:0] num;
        logic signed [CW-1:0] nmag;
        logic signed [DW-1:0] dabs;
        logic [MW-1:0]        dmag;
        logic [63:0]          n;
        ctl_next.vld  = v4_reg;
        ctl_next.sing = (det_reg == '0);
        dabs          = det_reg[DW-1] ? -det_reg : det_reg;
        dmag          = dabs[MW-1:0];
        ctl_next.den  = dmag;
        for (int k = 0; k < NL; k++)
        begin
            num  = cof4_reg[k % 3][k / 3];
            nmag = num[CW-1] ? -num : num;
            n    = 64'(nmag[QW-1:0]) << FRAC_BITS;
            ctl_next.neg[k]   = num[CW-1] ^ det_reg[DW-1];
            ctl_next.ovf[k]   = MW'(n[63:32]) >= dmag;
            lanes_next[k].rem = MW'(n[63:32]);
            lanes_next[k].lo  = n[31:0];
            lanes_next[k].q   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= vld;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign ctl   = ctl_reg;
    assign lanes = lanes_reg;

endmodule

// File: hw/rtl/mi3_cell.sv
module mi3_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  mi3_pkg::ctl_t   ctl_in,
    input  mi3_pkg::lanes_t lanes_in,
    output mi3_pkg::ctl_t   ctl_out,
    output mi3_pkg::lanes_t lanes_out
);
    import mi3_pkg::*;

    ctl_t   ctl_reg;
    lanes_t lanes_reg;
    lanes_t lanes_next;

    always_comb
    begin
        logic [MW:0] t;
        logic        ge;
        for (int k = 0; k < NL; k++)
        begin
            t  = {lanes_in[k].rem, lanes_in[k].lo[QW-1]};
            ge = t >= {1'b0, ctl_in.den};
            lanes_next[k].rem = ge ? MW'(t - {1'b0, ctl_in.den}) : t[MW-1:0];
            lanes_next[k].lo  = {lanes_in[k].lo[QW-2:0], 1'b0};
            lanes_next[k].q   = {lanes_in[k].q[QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign lanes_out = lanes_reg;

endmodule

// File: hw/rtl/matrix_inverse_3x3.sv
// Channel  Direction  Signals
// mat      in         mat_valid, mat_ready, mat (3x3 signed 16-bit entries)
// inv      out        inv_valid, inv_ready, inv (singular flag, Q16.16 inverse)
//
// One matrix transfer per cycle while the pipeline is not held.
// Each matrix passes through five cofactor and determinant stages, then one
// restoring divider cell per quotient bit, 32 cells in a row, then the output register.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears all valid flags; no clearing pass is needed.
module matrix_inverse_3x3 #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mat_valid,
    output logic          mat_ready,
    input  mi3_pkg::mat_t mat,
    output logic          inv_valid,
    input  logic          inv_ready,
    output mi3_pkg::inv_t inv
);
    import mi3_pkg::*;

    logic   en;
    ctl_t   ch_ctl   [NCELL+1];
    lanes_t ch_lanes [NCELL+1];

    logic          inv_valid_reg;
    inv_t          inv_reg;
    inv_t          inv_next;
    logic [QW-1:0] res [NL];

    assign en        = !inv_valid_reg || inv_ready;
    assign mat_ready = en;

    mi3_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vld   (mat_valid),
        .mat   (mat),
        .ctl   (ch_ctl[0]),
        .lanes (ch_lanes[0])
    );

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        mi3_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .ctl_in    (ch_ctl[i]),
            .lanes_in  (ch_lanes[i]),
            .ctl_out   (ch_ctl[i+1]),
            .lanes_out (ch_lanes[i+1])
        );
    end

    always_comb
    begin
        logic [QW-1:0] q;
        logic          big;
        for (int k = 0; k < NL; k++)
        begin
            q   = ch_lanes[NCELL][k].q;
            big = ch_ctl[NCELL].ovf[k] || q[QW-1];
            if (ch_ctl[NCELL].sing)
            begin
                res[k] = '0;
            end
            else if (ch_ctl[NCELL].neg[k])
            begin
                res[k] = big ? {1'b1, {(QW-1){1'b0}}} : -q;
            end
            else
            begin
                res[k] = big ? {1'b0, {(QW-1){1'b1}}} : q;
            end
        end
        inv_next.singular = ch_ctl[NCELL].sing;
        inv_next.b00 = res[0];
        inv_next.b01 = res[1];
        inv_next.b02 = res[2];
        inv_next.b10 = res[3];
        inv_next.b11 = res[4];
        inv_next.b12 = res[5];
        inv_next.b20 = res[6];
        inv_next.b21 = res[7];
        inv_next.b22 = res[8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            inv_valid_reg <= ch_ctl[NCELL].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg <= inv_next;
        end
    end

    assign inv_valid = inv_valid_reg;
    assign inv       = inv_reg;

endmodule
